FILE: sv/ckp_pkg.sv
package ckp_pkg;

    localparam int NEST_DEPTH_DEF = 8;
    localparam int POS_BITS_DEF   = 40;
    localparam int QUEUE_DEPTH    = 4;

    localparam int DELTA_W  = 32;
    localparam int RLEN_W   = 40;
    localparam int CFG_W    = 40;

    // configuration register indexes
    localparam logic CFG_OFFSET_DELTA  = 1'b0;
    localparam logic CFG_REGION_LENGTH = 1'b1;

    // box types, big-endian four-character codes
    localparam logic [31:0] T_STCO = 32'h7374636F;
    localparam logic [31:0] T_CO64 = 32'h636F3634;
    localparam logic [31:0] T_MOOV = 32'h6D6F6F76;
    localparam logic [31:0] T_TRAK = 32'h7472616B;
    localparam logic [31:0] T_MDIA = 32'h6D646961;
    localparam logic [31:0] T_MINF = 32'h6D696E66;
    localparam logic [31:0] T_STBL = 32'h7374626C;
    localparam logic [31:0] T_DINF = 32'h64696E66;

    typedef enum logic [1:0] {
        CLASS_OTHER = 2'd0,
        CLASS_STCO  = 2'd1,
        CLASS_CO64  = 2'd2
    } t_box_class;

    // one request from the parser to the byte emitter
    typedef struct packed {
        logic        is_entry;
        logic        wide;
        logic        done;
        logic [63:0] data;
    } t_cmd;

    function automatic logic is_container(input logic [31:0] t);
        return (t == T_MOOV) || (t == T_TRAK) || (t == T_MDIA) ||
               (t == T_MINF) || (t == T_STBL) || (t == T_DINF);
    endfunction

endpackage

FILE: sv/ckp_front.sv
module ckp_front #(
    parameter int NEST_DEPTH = ckp_pkg::NEST_DEPTH_DEF,
    parameter int POS_BITS   = ckp_pkg::POS_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [ckp_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                i_accept,
    input  logic [7:0]          i_data_byte,
    output logic                o_push,
    output ckp_pkg::t_cmd       o_cmd
);
    import ckp_pkg::*;

    localparam int LVL_W = $clog2(NEST_DEPTH);

    logic [DELTA_W-1:0]  r_delta;
    logic [RLEN_W-1:0]   r_rlen;
    logic [POS_BITS-1:0] r_pos, n_pos;
    logic [LVL_W-1:0]    r_nest, n_nest;
    logic [POS_BITS-1:0] r_rend [NEST_DEPTH];
    logic [POS_BITS-1:0] n_rend [NEST_DEPTH];
    logic [POS_BITS-1:0] r_bend [NEST_DEPTH];
    logic [POS_BITS-1:0] n_bend [NEST_DEPTH];
    logic [NEST_DEPTH-1:0] r_stop, n_stop;
    logic [63:0]         r_hs, n_hs;
    logic [31:0]         r_type, n_type;
    logic [4:0]          r_hidx, n_hidx;
    t_box_class          r_cls, n_cls;
    logic [31:0]         r_eleft, n_eleft;
    logic [63:0]         r_ebuf, n_ebuf;
    logic [3:0]          r_eidx, n_eidx;

    always_comb begin
        logic [63:0]         rl64;
        logic [POS_BITS-1:0] p;
        logic [POS_BITS-1:0] end0;
        logic [POS_BITS-1:0] rend_lv;
        logic [POS_BITS-1:0] start;
        logic [POS_BITS-1:0] rem;
        logic [POS_BITS-1:0] bend;
        logic [63:0]         size;
        logic [63:0]         v;
        logic [4:0]          hlen;
        logic [3:0]          esize;
        logic [LVL_W-1:0]    lv;
        logic                last;
        logic                rest;
        logic                do_open;
        logic                push;
        t_cmd                cmd;

        n_pos   = r_pos;
        n_nest  = r_nest;
        n_rend  = r_rend;
        n_bend  = r_bend;
        n_stop  = r_stop;
        n_hs    = r_hs;
        n_type  = r_type;
        n_hidx  = r_hidx;
        n_cls   = r_cls;
        n_eleft = r_eleft;
        n_ebuf  = r_ebuf;
        n_eidx  = r_eidx;
        push    = 1'b0;
        cmd     = '0;
        cmd.data = 64'(i_data_byte);
        do_open = 1'b0;
        rest    = 1'b0;
        hlen    = 5'd8;
        size    = '0;
        start   = '0;
        rem     = '0;
        bend    = '0;
        v       = '0;
        esize   = 4'd4;
        last    = 1'b0;
        lv      = '0;
        rend_lv = '0;

        p    = r_pos;
        rl64 = 64'(r_rlen);
        // region length saturates to the position width
        end0 = ((rl64 >> POS_BITS) != 64'd0) ? '1 : POS_BITS'(rl64);
        if (p == '0) begin
            n_rend[0] = end0;
        end else begin
            end0 = r_rend[0];
        end

        if (i_accept) begin
            if (end0 == '0) begin
                // empty region: pass with done, stay at the start
                push     = 1'b1;
                cmd.done = 1'b1;
                last     = 1'b1;
            end else begin
                last = (p + POS_BITS'(1) >= end0);
                push = 1'b1;
                cmd.done = last;

                // pop every level whose region has ended
                for (int l = 1; l < NEST_DEPTH; l++) begin
                    if (LVL_W'(l) <= r_nest && p < r_rend[l]) begin
                        lv = LVL_W'(l);
                    end
                end
                n_nest = lv;
                if (lv != r_nest) begin
                    n_hidx  = '0;
                    n_cls   = CLASS_OTHER;
                    n_eleft = '0;
                    n_eidx  = '0;
                    n_ebuf  = '0;
                end
                rend_lv = n_rend[lv];

                if (r_stop[lv]) begin
                    // level stopped: pass
                end else if (p >= r_bend[lv]) begin
                    // box header byte
                    if (n_hidx == 5'd0 && (rend_lv - p) < POS_BITS'(8)) begin
                        n_stop[lv] = 1'b1;
                    end else begin
                        if (n_hidx == 5'd0) begin
                            n_hs = 64'(i_data_byte);
                        end else if (n_hidx >= 5'd4 && n_hidx < 5'd8) begin
                            n_type = {r_type[23:0], i_data_byte};
                        end else begin
                            n_hs = {n_hs[55:0], i_data_byte};
                        end
                        n_hidx = n_hidx + 5'd1;
                        if (n_hidx == 5'd8) begin
                            if (n_hs[31:0] == 32'd1) begin
                                if ((rend_lv - (p - POS_BITS'(7))) < POS_BITS'(16)) begin
                                    n_stop[lv] = 1'b1;
                                    n_hidx     = '0;
                                end
                            end else if (n_hs[31:0] >= 32'd2 && n_hs[31:0] < 32'd8) begin
                                n_stop[lv] = 1'b1;
                                n_hidx     = '0;
                            end else begin
                                do_open = 1'b1;
                                hlen    = 5'd8;
                                size    = {32'd0, n_hs[31:0]};
                                rest    = (n_hs[31:0] == 32'd0);
                            end
                        end else if (n_hidx == 5'd16) begin
                            if (n_hs < 64'd16) begin
                                n_stop[lv] = 1'b1;
                                n_hidx     = '0;
                            end else begin
                                do_open = 1'b1;
                                hlen    = 5'd16;
                                size    = n_hs;
                            end
                        end
                    end

                    if (do_open) begin
                        start = p + POS_BITS'(1) - POS_BITS'(hlen);
                        rem   = rend_lv - start;
                        bend  = (rest || size > 64'(rem)) ? rend_lv : start + POS_BITS'(size);
                        n_bend[lv] = bend;
                        n_hidx  = '0;
                        n_cls   = CLASS_OTHER;
                        n_eleft = '0;
                        n_eidx  = '0;
                        n_ebuf  = '0;
                        if ((n_type == T_STCO || n_type == T_CO64) &&
                            (bend - start) >= POS_BITS'(hlen + 5'd8)) begin
                            n_cls  = (n_type == T_STCO) ? CLASS_STCO : CLASS_CO64;
                            n_hidx = 5'd16;
                        end else if (is_container(n_type) && bend > p + POS_BITS'(1) &&
                                     (int'(lv) + 1) < NEST_DEPTH) begin
                            n_nest = lv + LVL_W'(1);
                            n_rend[lv + LVL_W'(1)] = bend;
                            n_bend[lv + LVL_W'(1)] = p + POS_BITS'(1);
                            n_stop[lv + LVL_W'(1)] = 1'b0;
                        end
                    end
                end else begin
                    // box body
                    esize = (n_cls == CLASS_STCO) ? 4'd4 : 4'd8;
                    if (n_cls != CLASS_OTHER && n_hidx < 5'd24) begin
                        if (n_hidx >= 5'd20) begin
                            n_eleft = {n_eleft[23:0], i_data_byte};
                        end
                        n_hidx = n_hidx + 5'd1;
                    end else if (n_cls != CLASS_OTHER &&
                                 (n_eidx != '0 || n_eleft != '0)) begin
                        if (n_eidx == '0 && (r_bend[lv] - p) < POS_BITS'(esize)) begin
                            n_eleft = '0;
                        end else begin
                            n_ebuf = {n_ebuf[55:0], i_data_byte};
                            n_eidx = n_eidx + 4'd1;
                            push   = 1'b0;
                            if (n_eidx == esize) begin
                                if (esize == 4'd4) begin
                                    v = {32'd0, n_ebuf[31:0] + r_delta};
                                end else begin
                                    v = n_ebuf + 64'(r_delta);
                                end
                                push         = 1'b1;
                                cmd.is_entry = 1'b1;
                                cmd.wide     = (esize == 4'd8);
                                cmd.data     = v;
                                n_eleft = n_eleft - 32'd1;
                                n_eidx  = '0;
                                n_ebuf  = '0;
                            end
                        end
                    end
                    if (p + POS_BITS'(1) == r_bend[lv]) begin
                        n_hidx  = '0;
                        n_cls   = CLASS_OTHER;
                        n_eleft = '0;
                        n_eidx  = '0;
                        n_ebuf  = '0;
                    end
                end
            end

            if (last) begin
                n_pos     = '0;
                n_nest    = '0;
                n_stop    = '0;
                n_hs      = '0;
                n_type    = '0;
                n_bend[0] = '0;
                n_hidx    = '0;
                n_cls     = CLASS_OTHER;
                n_eleft   = '0;
                n_eidx    = '0;
                n_ebuf    = '0;
            end else begin
                n_pos = p + POS_BITS'(1);
            end
        end else begin
            n_rend = r_rend;
        end

        o_push = push;
        o_cmd  = cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta <= '0;
            r_rlen  <= '0;
            r_pos   <= '0;
            r_nest  <= '0;
            r_stop  <= '0;
            r_hs    <= '0;
            r_type  <= '0;
            r_hidx  <= '0;
            r_cls   <= CLASS_OTHER;
            r_eleft <= '0;
            r_ebuf  <= '0;
            r_eidx  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OFFSET_DELTA:  r_delta <= i_cfg_data[DELTA_W-1:0];
                    CFG_REGION_LENGTH: r_rlen  <= i_cfg_data[RLEN_W-1:0];
                    default: ;
                endcase
            end
            r_pos   <= n_pos;
            r_nest  <= n_nest;
            r_stop  <= n_stop;
            r_hs    <= n_hs;
            r_type  <= n_type;
            r_hidx  <= n_hidx;
            r_cls   <= n_cls;
            r_eleft <= n_eleft;
            r_ebuf  <= n_ebuf;
            r_eidx  <= n_eidx;
        end
    end

    // the top-level box end starts at zero so the first byte is a header byte
    always_ff @(posedge i_clk) begin
        r_rend <= n_rend;
        if (!i_rst_n) begin
            r_bend <= '{default: '0};
        end else begin
            r_bend <= n_bend;
        end
    end

`ifndef SYNTH
    a_entry_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_eidx != '0 |-> r_cls != CLASS_OTHER)
        else $error("entry bytes held outside an offset table");
    a_entry_push_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_cmd.is_entry) |-> (r_eidx == 4'd3 || r_eidx == 4'd7))
        else $error("entry emitted before all its bytes arrived");
`endif

endmodule

FILE: sv/ckp_queue.sv
module ckp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ckp_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output ckp_pkg::t_cmd o_cmd
);
    import ckp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_cmd               r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [PTR_W:0]     r_count;

    assign o_full  = (r_count == (PTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            r_count <= r_count + (PTR_W + 1)'(i_push) - (PTR_W + 1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("request queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("request queue underflow");
`endif

endmodule

FILE: sv/ckp_back.sv
module ckp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  ckp_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [7:0]    o_out_byte,
    output logic          o_in_entry,
    output logic          o_region_done
);
    import ckp_pkg::*;

    logic        r_valid;
    t_cmd        r_cmd;
    logic [2:0]  r_sel;
    logic        take;
    logic        load;

    assign take    = r_valid && !i_stall;
    assign load    = i_q_valid && (!r_valid || (take && r_sel == 3'd0));
    assign o_q_pop = load;

    assign o_valid       = r_valid;
    assign o_out_byte    = r_cmd.data[{r_sel, 3'b000} +: 8];
    assign o_in_entry    = r_cmd.is_entry;
    assign o_region_done = r_cmd.done && (r_sel == 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_sel   <= !i_q_cmd.is_entry ? 3'd0 : (i_q_cmd.wide ? 3'd7 : 3'd3);
        end else if (take) begin
            if (r_sel == 3'd0) begin
                r_valid <= 1'b0;
            end else begin
                r_sel <= r_sel - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_q_cmd;
        end
    end

`ifndef SYNTH
    a_pass_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_cmd.is_entry) |-> r_sel == 3'd0)
        else $error("passed byte spread over several outputs");
    a_stco_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_cmd.is_entry && !r_cmd.wide) |-> r_sel <= 3'd3)
        else $error("32-bit entry emitting beyond four bytes");
`endif

endmodule

FILE: sv/mp4_chunk_offset_patcher.sv
// MP4 chunk offset patcher: streams the payload of a moov box one byte per
// request, walks the nested box headers (descending into moov, trak, mdia,
// minf, stbl and dinf up to NEST_DEPTH levels) and adds offset_delta to
// every entry of stco (mod 2^32) and co64 (mod 2^64) tables; all other bytes
// pass unchanged. Program offset_delta (index 0) and region_length (index 1)
// while idle; the length is latched on the first byte of each region and
// o_region_done marks the last byte out. Throughput is one byte per cycle
// while i_stall is low: the parser takes a byte every cycle unless its
// four-request queue is full, and the emitter puts out one byte per cycle
// unless stalled. Table entries are held in the parser until their last
// byte arrives and then leave as a burst of consecutive bytes. A passed
// byte is registered in the queue and then in the emitter before it leaves.
module mp4_chunk_offset_patcher #(
    parameter int NEST_DEPTH = ckp_pkg::NEST_DEPTH_DEF,
    parameter int POS_BITS   = ckp_pkg::POS_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration writes
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [ckp_pkg::CFG_W-1:0] i_cfg_data,
    // input byte channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [7:0]                i_data_byte,
    // output byte channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [7:0]                o_out_byte,
    output logic                      o_in_entry,
    output logic                      o_region_done
);
    import ckp_pkg::*;

    logic q_full;
    logic q_valid;
    logic q_pop;
    logic push;
    logic accept;
    t_cmd front_cmd;
    t_cmd q_cmd;

    // the parser only stalls when the request queue has no room
    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    // parser: header walk, level stack, entry assembly and add
    ckp_front #(
        .NEST_DEPTH (NEST_DEPTH),
        .POS_BITS   (POS_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    // short queue decoupling the parser from the emitter
    ckp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // emitter: one byte per cycle unless i_stall is high, entries serialized big-endian
    ckp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_cmd),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_in_entry    (o_in_entry),
        .o_region_done (o_region_done)
    );

endmodule
